[rtl/core/annexb_nal_unit_splitter_unit_assert.svh]
// Assertion macros shared by the splitter RTL.
// Each macro places one labeled concurrent assertion, clocked on the rising edge
// and disabled while the active-low reset is asserted.
`ifndef ANNEXB_NAL_UNIT_SPLITTER_UNIT_ASSERT_SVH
`define ANNEXB_NAL_UNIT_SPLITTER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ANBNAL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("splitter assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ANBNAL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("splitter assertion failed");

`endif

[rtl/core/anbnal_pkg.sv]
`default_nettype none

package anbnal_pkg;

	localparam int LENGTH_WIDTH_DEFAULT = 24;
	localparam int OFFSET_WIDTH_DEFAULT = 32;

	// Result status codes.
	localparam logic STATUS_UNIT     = 1'b0;
	localparam logic STATUS_NO_START = 1'b1;

	// Start code prefix lengths in bytes.
	localparam int PREFIX_SHORT = 3;
	localparam int PREFIX_LONG  = 4;

	localparam logic [7:0] START_BYTE = 8'h01;

endpackage

`default_nettype wire

[rtl/core/anbnal_if.sv]
`default_nettype none

interface anbnal_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, data_byte, last_byte, input ready);
	modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface anbnal_desc_if
	import anbnal_pkg::*;
#(
	parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEFAULT,
	parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEFAULT
);
	logic                    valid;
	logic                    ready;
	logic                    status;
	logic                    fz_bit;
	logic [1:0]              ref_idc;
	logic [4:0]              unit_type;
	logic [LENGTH_WIDTH-1:0] payload_len;
	logic [LENGTH_WIDTH-1:0] total_len;
	logic [OFFSET_WIDTH-1:0] unit_offset;
	logic                    len_saturated;

	modport source (output valid, status, fz_bit, ref_idc, unit_type, payload_len,
		total_len, unit_offset, len_saturated, input ready);
	modport sink (input valid, status, fz_bit, ref_idc, unit_type, payload_len,
		total_len, unit_offset, len_saturated, output ready);
endinterface

`default_nettype wire

[rtl/core/annexb_nal_unit_splitter_unit.sv]
// Annex B start code splitter for H.264 byte streams.
// The stream channel carries one byte per item with a flag on the final byte of a stream.
// The desc channel carries one item per NAL unit: the header fields of its first payload
// byte, its payload length, its length with the prefix, and the offset of its prefix.
// A stream that does not open with a 00 00 01 or 00 00 00 01 prefix yields a single item
// with status set and all other fields zero; after that, bytes are taken and dropped
// until reset.
// Throughput is one byte per cycle while ready is high: each byte needs only window compares
// and one increment, add and compare on the length counter, all combinational.
// A result is registered into the output buffer on the byte that completes the next start code
// or ends the stream. Two output registers buffer results, so the block keeps taking
// bytes while one result waits; ready drops only when both registers are full.
// After the final byte of a stream that did not halt, the parser returns to its reset state,
// and the next byte starts a new stream at offset 0.
// Reset (arst_n low) clears the parser and empties the output registers.
`default_nettype none

module annexb_nal_unit_splitter_unit
	import anbnal_pkg::*;
#(
	parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEFAULT,
	parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEFAULT
) (
	input  wire            clk,
	input  wire            arst_n,
	anbnal_byte_if.sink    stream,
	anbnal_desc_if.source  desc
);

	localparam int LW = LENGTH_WIDTH;
	localparam int OW = OFFSET_WIDTH;
	localparam logic [LW-1:0] LEN_MAX = {LW{1'b1}};

	typedef enum logic [1:0] {
		SEEK,
		IN_UNIT,
		HALTED
	} phase_t;

	typedef struct packed {
		logic          status;
		logic          fz_bit;
		logic [1:0]    ref_idc;
		logic [4:0]    unit_type;
		logic [LW-1:0] payload_len;
		logic [LW-1:0] total_len;
		logic [OW-1:0] unit_offset;
		logic          len_saturated;
	} desc_t;

	// Parser state.
	phase_t        phase_q, phase_n;
	logic [23:0]   win_q, win_n;
	logic          four_q, four_n;
	logic [LW-1:0] count_q, count_n;
	logic [OW-1:0] uoff_q, uoff_n;
	logic [OW-1:0] pos_q, pos_n;
	logic [7:0]    hdr_q, hdr_n;
	logic          sat_q, sat_n;

	// Output buffer: head drives the port, skid holds a second result.
	desc_t head_q, skid_q;
	logic  head_v_q, skid_v_q;

	logic  accept, push, pop;
	desc_t res;

	logic [LW:0]   inc_w;
	logic [LW-1:0] cnt;
	logic          sat_e;
	logic          is_four, is_three, start3, start4;
	logic [LW-1:0] new_len, payload;
	logic [LW:0]   total_w;
	logic [7:0]    hdr_e;

	assign stream.ready = !skid_v_q;
	assign accept       = stream.valid && stream.ready;
	assign pop          = head_v_q && desc.ready;

	always_comb begin
		phase_n = phase_q;
		win_n   = win_q;
		four_n  = four_q;
		count_n = count_q;
		uoff_n  = uoff_q;
		pos_n   = pos_q;
		hdr_n   = hdr_q;
		sat_n   = sat_q;
		push    = 1'b0;
		res     = '0;

		start3   = (pos_q == OW'(2)) && (win_q[15:0] == 16'h0000)
			&& (stream.data_byte == START_BYTE);
		start4   = (pos_q == OW'(3)) && (win_q == 24'h000000)
			&& (stream.data_byte == START_BYTE);
		is_four  = (win_q == 24'h000000) && (stream.data_byte == START_BYTE);
		is_three = !is_four && (win_q[15:0] == 16'h0000) && (stream.data_byte == START_BYTE);

		// Saturating payload byte count including this byte.
		inc_w = {1'b0, count_q} + {{LW{1'b0}}, 1'b1};
		sat_e = sat_q || (inc_w >= {1'b0, LEN_MAX});
		cnt   = sat_e ? LEN_MAX : inc_w[LW-1:0];
		hdr_e = (cnt == LW'(1)) ? stream.data_byte : hdr_q;

		// A closing start code's own bytes are not part of the unit being closed.
		new_len = is_four ? LW'(PREFIX_LONG) : LW'(PREFIX_SHORT);
		if (is_four || is_three) begin
			payload = (cnt >= new_len) ? cnt - new_len : '0;
		end else begin
			payload = cnt;
		end
		total_w = {1'b0, payload}
			+ (four_q ? (LW + 1)'(PREFIX_LONG) : (LW + 1)'(PREFIX_SHORT));

		if (accept) begin
			unique case (phase_q)
				SEEK: begin
					if (!(start3 || start4) && ((pos_q >= OW'(3)) || stream.last_byte)) begin
						push       = 1'b1;
						res.status = STATUS_NO_START;
						phase_n    = HALTED;
					end else if (stream.last_byte) begin
						phase_n = SEEK;
						win_n   = '0;
						four_n  = 1'b0;
						count_n = '0;
						uoff_n  = '0;
						pos_n   = '0;
						hdr_n   = '0;
						sat_n   = 1'b0;
					end else begin
						if (start3 || start4) begin
							phase_n = IN_UNIT;
							four_n  = start4;
							count_n = '0;
							sat_n   = 1'b0;
							hdr_n   = '0;
							uoff_n  = '0;
						end
						win_n = {win_q[15:0], stream.data_byte};
						pos_n = pos_q + OW'(1);
					end
				end
				IN_UNIT: begin
					if (is_four || is_three || stream.last_byte) begin
						push              = 1'b1;
						res.status        = STATUS_UNIT;
						res.fz_bit        = (payload != '0) ? hdr_e[7] : 1'b0;
						res.ref_idc       = (payload != '0) ? hdr_e[6:5] : 2'b00;
						res.unit_type     = (payload != '0) ? hdr_e[4:0] : 5'b00000;
						res.unit_offset   = uoff_q;
						if (sat_e) begin
							res.payload_len   = LEN_MAX;
							res.total_len     = LEN_MAX;
							res.len_saturated = 1'b1;
						end else if (total_w >= {1'b0, LEN_MAX}) begin
							res.payload_len   = payload;
							res.total_len     = LEN_MAX;
							res.len_saturated = 1'b1;
						end else begin
							res.payload_len   = payload;
							res.total_len     = total_w[LW-1:0];
							res.len_saturated = 1'b0;
						end
					end
					if (stream.last_byte) begin
						phase_n = SEEK;
						win_n   = '0;
						four_n  = 1'b0;
						count_n = '0;
						uoff_n  = '0;
						pos_n   = '0;
						hdr_n   = '0;
						sat_n   = 1'b0;
					end else begin
						if (is_four || is_three) begin
							four_n  = is_four;
							count_n = '0;
							sat_n   = 1'b0;
							hdr_n   = '0;
							// The new prefix began two or three bytes before this one.
							uoff_n  = pos_q - (is_four ? OW'(PREFIX_LONG - 1)
								: OW'(PREFIX_SHORT - 1));
						end else begin
							count_n = cnt;
							sat_n   = sat_e;
							hdr_n   = hdr_e;
						end
						win_n = {win_q[15:0], stream.data_byte};
						pos_n = pos_q + OW'(1);
					end
				end
				HALTED: begin
					phase_n = HALTED;
				end
				default: begin
					phase_n = HALTED;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= SEEK;
			win_q   <= '0;
			four_q  <= 1'b0;
			count_q <= '0;
			uoff_q  <= '0;
			pos_q   <= '0;
			hdr_q   <= '0;
			sat_q   <= 1'b0;
		end else begin
			phase_q <= phase_n;
			win_q   <= win_n;
			four_q  <= four_n;
			count_q <= count_n;
			uoff_q  <= uoff_n;
			pos_q   <= pos_n;
			hdr_q   <= hdr_n;
			sat_q   <= sat_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (pop) begin
				if (skid_v_q) begin
					head_v_q <= 1'b1;
					skid_v_q <= 1'b0;
				end else begin
					head_v_q <= push;
				end
			end else if (push) begin
				if (head_v_q) begin
					skid_v_q <= 1'b1;
				end else begin
					head_v_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_v_q) begin
				head_q <= skid_q;
			end else if (push) begin
				head_q <= res;
			end
		end else if (push) begin
			if (head_v_q) begin
				skid_q <= res;
			end else begin
				head_q <= res;
			end
		end
	end

	assign desc.valid         = head_v_q;
	assign desc.status        = head_q.status;
	assign desc.fz_bit        = head_q.fz_bit;
	assign desc.ref_idc       = head_q.ref_idc;
	assign desc.unit_type     = head_q.unit_type;
	assign desc.payload_len   = head_q.payload_len;
	assign desc.total_len     = head_q.total_len;
	assign desc.unit_offset   = head_q.unit_offset;
	assign desc.len_saturated = head_q.len_saturated;

`include "annexb_nal_unit_splitter_unit_assert.svh"

	`ANBNAL_ASSERT_SAME(a_skid_behind_head, clk, arst_n, skid_v_q, head_v_q)
	`ANBNAL_ASSERT_SAME(a_halted_silent, clk, arst_n, phase_q == HALTED, !push)
	`ANBNAL_ASSERT_SAME(a_seek_pos_small, clk, arst_n, phase_q == SEEK, pos_q <= OW'(3))
	`ANBNAL_ASSERT_NEXT(a_error_halts, clk, arst_n, push && res.status == STATUS_NO_START,
		phase_q == HALTED)

endmodule

`default_nettype wire
